// ----- rtl/core/json_byte_tokenizer_unit_defines.svh -----
// Assertion macros for the tokenizer RTL, used by the parser
`ifndef JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define JBT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");
// Next-cycle implication, checked out of reset
`define JBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");
`else
`define JBT_ASSERT_IMPL(label, ante, cons)
`define JBT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/jbt_pkg.sv -----
// Types, constants and codes shared by the tokenizer modules
package jbt_pkg;

    localparam int NUM_BITS  = 16;
    localparam int STR_LEN   = 16;
    localparam int MAX_DEPTH = 15;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    localparam logic [3:0] DEPTH_MAX = 4'(MAX_DEPTH);
    localparam logic [3:0] TEXT_LAST = 4'(STR_LEN - 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    typedef enum logic [3:0] {
        CLS_WHITE,
        CLS_RESET,
        CLS_DIGIT,
        CLS_TRUE,
        CLS_FALSE,
        CLS_LETTER,
        CLS_LBRACE,
        CLS_RBRACE,
        CLS_COLON,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_COMMA,
        CLS_QUOTE,
        CLS_OTHER
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NAME,
        ST_SEP,
        ST_VALUE,
        ST_ARRAY,
        ST_CONT,
        ST_ACONT
    } parse_state_t;

    typedef enum logic [1:0] {
        SUB_NONE,
        SUB_NUM,
        SUB_BOOL,
        SUB_STR
    } sub_state_t;

    typedef enum logic [3:0] {
        EV_NONE,
        EV_TEXT,
        EV_NAME_DONE,
        EV_VALUE_DONE,
        EV_ELEM_DONE,
        EV_OPEN,
        EV_CLOSE,
        EV_ROOT_CLOSE,
        EV_EMPTY_CLOSE,
        EV_RESET,
        EV_ERROR,
        EV_ARRAY_OPEN,
        EV_ARRAY_CLOSE
    } evt_t;

    typedef enum logic [2:0] {
        ERR_BRACE,
        ERR_QUOTE,
        ERR_COLON,
        ERR_CONT,
        ERR_VALUE,
        ERR_ACONT,
        ERR_DEPTH
    } err_t;

    typedef enum logic [1:0] {
        KIND_STR,
        KIND_NUM,
        KIND_BOOL
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        cls_t       cls;
    } item_t;

    typedef struct packed {
        evt_t                ev;
        err_t                err;
        kind_t               kind;
        logic [NUM_BITS-1:0] num;
        logic                bval;
        logic [7:0]          ch;
        logic [3:0]          idx;
        logic [3:0]          nest;
        logic                last;
    } res_t;

    // Results of one parsed character: cnt of them, r0 first
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } wr_t;

endpackage

// ----- rtl/core/jbt_front.sv -----
// Input side: takes characters and tags each with its character class
module jbt_front (
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_char,
    input  logic          q_full,
    output logic          q_push,
    output jbt_pkg::item_t q_item
);
    import jbt_pkg::*;

    cls_t cls;

    always_comb
    begin
        case (in_char) inside
            CH_SPACE, CH_NL, CH_CR, CH_TAB: cls = CLS_WHITE;
            CH_NUL, CH_ESC:                 cls = CLS_RESET;
            [CH_ZERO:CH_NINE]:              cls = CLS_DIGIT;
            CH_LO_T, CH_UP_T:               cls = CLS_TRUE;
            CH_LO_F, CH_UP_F:               cls = CLS_FALSE;
            [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]: cls = CLS_LETTER;
            CH_LBRACE:                      cls = CLS_LBRACE;
            CH_RBRACE:                      cls = CLS_RBRACE;
            CH_COLON:                       cls = CLS_COLON;
            CH_LBRACK:                      cls = CLS_LBRACK;
            CH_RBRACK:                      cls = CLS_RBRACK;
            CH_COMMA:                       cls = CLS_COMMA;
            CH_QUOTE:                       cls = CLS_QUOTE;
            default:                        cls = CLS_OTHER;
        endcase
    end

    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full;
    assign q_item.ch  = in_char;
    assign q_item.cls = cls;

endmodule

// ----- rtl/core/jbt_queue.sv -----
// Short queue of classified characters between the front and the parser
module jbt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jbt_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output jbt_pkg::item_t head
);
    import jbt_pkg::*;

    item_t             q_mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign head   = q_mem[rptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wptr_next = push   ? QPTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = do_pop ? QPTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/jbt_back.sv -----
// Parser: grammar state machine, token accumulation and result forming
`include "json_byte_tokenizer_unit_defines.svh"

module jbt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  jbt_pkg::item_t q_item,
    input  logic           q_empty,
    input  logic           space_ok,
    output logic           q_pop,
    output jbt_pkg::wr_t   wr
);
    import jbt_pkg::*;

    parse_state_t        state_reg, state_next;
    sub_state_t          sub_reg, sub_next;
    logic [3:0]          depth_reg, depth_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic                bool_reg, bool_next;
    logic [3:0]          tlen_reg, tlen_next;

    function automatic res_t make_res(evt_t ev, err_t er, kind_t kd,
                                      logic [NUM_BITS-1:0] num, logic b,
                                      logic [7:0] ch, logic [3:0] idx,
                                      logic [3:0] nest);
        res_t r;
        r.ev   = ev;
        r.err  = er;
        r.kind = kd;
        r.num  = num;
        r.bval = b;
        r.ch   = ch;
        r.idx  = idx;
        r.nest = nest;
        r.last = 1'b0;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sub_reg   <= SUB_NONE;
            depth_reg <= '0;
            acc_reg   <= '0;
            bool_reg  <= 1'b0;
            tlen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            depth_reg <= depth_next;
            acc_reg   <= acc_next;
            bool_reg  <= bool_next;
            tlen_reg  <= tlen_next;
        end
    end

    always_comb
    begin
        logic                pending;
        logic                done;
        logic                tok_fire;
        logic                str_fire;
        res_t                tok_res;
        res_t                str_res;
        kind_t               kind;
        logic                bval;
        logic [3:0]          idx;
        logic [NUM_BITS-1:0] num;
        evt_t                dev;
        logic [NUM_BITS-1:0] digit;
        logic                is_letter;

        state_next = state_reg;
        sub_next   = sub_reg;
        depth_next = depth_reg;
        acc_next   = acc_reg;
        bool_next  = bool_reg;
        tlen_next  = tlen_reg;

        pending   = 1'b1;
        done      = 1'b0;
        tok_fire  = 1'b0;
        str_fire  = 1'b0;
        tok_res   = '0;
        str_res   = '0;
        kind      = KIND_STR;
        bval      = 1'b0;
        idx       = '0;
        num       = '0;
        dev       = EV_VALUE_DONE;
        digit     = NUM_BITS'(q_item.ch[3:0]);
        is_letter = q_item.cls inside {CLS_TRUE, CLS_FALSE, CLS_LETTER};

        q_pop = !q_empty && space_ok;

        if (!q_pop || (q_item.cls == CLS_WHITE && sub_reg != SUB_STR))
        begin
            // hold: nothing to do, or whitespace outside a string
        end
        else if (q_item.cls == CLS_RESET)
        begin
            state_next = ST_IDLE;
            sub_next   = SUB_NONE;
            depth_next = '0;
            acc_next   = '0;
            bool_next  = 1'b0;
            tlen_next  = '0;
            str_fire   = 1'b1;
            str_res    = make_res(EV_RESET, ERR_BRACE, KIND_STR, '0, 1'b0, '0, '0, '0);
        end
        else
        begin
            // finish or extend the open token first
            case (sub_reg)
                SUB_NUM:
                begin
                    if (q_item.cls == CLS_DIGIT)
                    begin
                        acc_next = {acc_reg[NUM_BITS-4:0], 3'b000}
                                 + {acc_reg[NUM_BITS-2:0], 1'b0} + digit;
                    end
                    else
                    begin
                        done = 1'b1;
                        kind = KIND_NUM;
                        num  = acc_reg;
                    end
                end
                SUB_BOOL:
                begin
                    if (!is_letter)
                    begin
                        done = 1'b1;
                        kind = KIND_BOOL;
                        bval = bool_reg;
                    end
                end
                SUB_STR:
                begin
                    if (q_item.cls == CLS_QUOTE)
                    begin
                        done    = 1'b1;
                        kind    = KIND_STR;
                        idx     = tlen_reg;
                        pending = 1'b0;
                    end
                    else if (tlen_reg < TEXT_LAST)
                    begin
                        tok_fire  = 1'b1;
                        tok_res   = make_res(EV_TEXT, ERR_BRACE, KIND_STR, '0, 1'b0,
                                             q_item.ch, tlen_reg, depth_reg);
                        tlen_next = tlen_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase

            if (done)
            begin
                case (state_reg)
                    ST_NAME:
                    begin
                        dev        = EV_NAME_DONE;
                        state_next = ST_SEP;
                    end
                    ST_ARRAY:
                    begin
                        dev        = EV_ELEM_DONE;
                        state_next = ST_ACONT;
                    end
                    default:
                    begin
                        dev        = EV_VALUE_DONE;
                        state_next = ST_CONT;
                    end
                endcase
                sub_next = SUB_NONE;
                tok_fire = 1'b1;
                tok_res  = make_res(dev, ERR_BRACE, kind, num, bval, '0, idx, depth_reg);
            end

            // then parse the character as structure
            if (sub_next == SUB_NONE && pending)
            begin
                str_fire = 1'b1;
                case (state_next)
                    ST_IDLE:
                    begin
                        if (q_item.cls == CLS_LBRACE)
                        begin
                            state_next = ST_NAME;
                            str_res = make_res(EV_OPEN, ERR_BRACE, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                        else
                        begin
                            str_res = make_res(EV_ERROR, ERR_BRACE, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                    end
                    ST_NAME:
                    begin
                        if (q_item.cls == CLS_RBRACE)
                        begin
                            state_next = ST_IDLE;
                            str_res = make_res(EV_EMPTY_CLOSE, ERR_BRACE, KIND_STR, '0,
                                               1'b0, '0, '0, depth_next);
                        end
                        else if (q_item.cls == CLS_QUOTE)
                        begin
                            str_fire  = 1'b0;
                            sub_next  = SUB_STR;
                            tlen_next = '0;
                        end
                        else
                        begin
                            str_res = make_res(EV_ERROR, ERR_QUOTE, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                    end
                    ST_SEP:
                    begin
                        if (q_item.cls == CLS_COLON)
                        begin
                            str_fire   = 1'b0;
                            state_next = ST_VALUE;
                        end
                        else
                        begin
                            str_res = make_res(EV_ERROR, ERR_COLON, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                    end
                    ST_VALUE, ST_ARRAY:
                    begin
                        case (q_item.cls)
                            CLS_QUOTE:
                            begin
                                str_fire  = 1'b0;
                                sub_next  = SUB_STR;
                                tlen_next = '0;
                            end
                            CLS_DIGIT:
                            begin
                                str_fire = 1'b0;
                                sub_next = SUB_NUM;
                                acc_next = digit;
                            end
                            CLS_TRUE, CLS_FALSE:
                            begin
                                str_fire  = 1'b0;
                                sub_next  = SUB_BOOL;
                                bool_next = (q_item.cls == CLS_TRUE);
                            end
                            CLS_LBRACK:
                            begin
                                if (state_next == ST_VALUE)
                                begin
                                    state_next = ST_ARRAY;
                                    str_res = make_res(EV_ARRAY_OPEN, ERR_BRACE, KIND_STR,
                                                       '0, 1'b0, '0, '0, depth_next);
                                end
                                else
                                begin
                                    str_res = make_res(EV_ERROR, ERR_VALUE, KIND_STR, '0,
                                                       1'b0, '0, '0, depth_next);
                                end
                            end
                            CLS_LBRACE:
                            begin
                                if (depth_next >= DEPTH_MAX)
                                begin
                                    str_res = make_res(EV_ERROR, ERR_DEPTH, KIND_STR, '0,
                                                       1'b0, '0, '0, depth_next);
                                end
                                else
                                begin
                                    depth_next = depth_next + 4'd1;
                                    state_next = ST_NAME;
                                    str_res = make_res(EV_OPEN, ERR_BRACE, KIND_STR, '0,
                                                       1'b0, '0, '0, depth_next);
                                end
                            end
                            default:
                            begin
                                str_res = make_res(EV_ERROR, ERR_VALUE, KIND_STR, '0,
                                                   1'b0, '0, '0, depth_next);
                            end
                        endcase
                    end
                    ST_CONT:
                    begin
                        if (q_item.cls == CLS_RBRACE)
                        begin
                            if (depth_next != '0)
                            begin
                                depth_next = depth_next - 4'd1;
                                str_res = make_res(EV_CLOSE, ERR_BRACE, KIND_STR, '0, 1'b0,
                                                   '0, '0, depth_next);
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                                str_res = make_res(EV_ROOT_CLOSE, ERR_BRACE, KIND_STR, '0,
                                                   1'b0, '0, '0, depth_next);
                            end
                        end
                        else if (q_item.cls == CLS_COMMA)
                        begin
                            str_fire   = 1'b0;
                            state_next = ST_NAME;
                        end
                        else
                        begin
                            str_res = make_res(EV_ERROR, ERR_CONT, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                    end
                    ST_ACONT:
                    begin
                        if (q_item.cls == CLS_RBRACK)
                        begin
                            state_next = ST_CONT;
                            str_res = make_res(EV_ARRAY_CLOSE, ERR_BRACE, KIND_STR, '0,
                                               1'b0, '0, '0, depth_next);
                        end
                        else if (q_item.cls == CLS_COMMA)
                        begin
                            str_fire   = 1'b0;
                            state_next = ST_ARRAY;
                        end
                        else
                        begin
                            str_res = make_res(EV_ERROR, ERR_ACONT, KIND_STR, '0, 1'b0,
                                               '0, '0, depth_next);
                        end
                    end
                    default:
                    begin
                        str_fire = 1'b0;
                    end
                endcase
            end
        end

        // pack the results in order and mark the final one
        tok_res.last = !str_fire;
        str_res.last = 1'b1;
        wr.cnt = 2'(tok_fire) + 2'(str_fire);
        wr.r0  = tok_fire ? tok_res : str_res;
        wr.r1  = str_res;
    end

    `JBT_ASSERT_IMPL(a_depth_bound, 1'b1, depth_reg <= DEPTH_MAX)
    `JBT_ASSERT_NEXT(a_reset_clears, q_pop && q_item.cls == CLS_RESET,
        state_reg == ST_IDLE && sub_reg == SUB_NONE && depth_reg == '0)
    `JBT_ASSERT_IMPL(a_token_context, sub_reg != SUB_NONE,
        state_reg == ST_NAME || state_reg == ST_VALUE || state_reg == ST_ARRAY)

endmodule

// ----- rtl/core/jbt_outbuf.sv -----
// Result buffer: takes up to two results a cycle, hands out one per transfer
module jbt_outbuf (
    input  logic          clk,
    input  logic          rst_n,
    input  jbt_pkg::wr_t  wr,
    output logic          space_ok,
    output logic          out_valid,
    input  logic          out_ready,
    output jbt_pkg::res_t head
);
    import jbt_pkg::*;

    res_t              o_mem [ODEPTH];
    logic [OPTR_W-1:0] wptr_reg, wptr_next;
    logic [OPTR_W-1:0] rptr_reg, rptr_next;
    logic [OCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = o_mem[rptr_reg];
    assign do_pop    = out_valid && out_ready;
    assign space_ok  = (cnt_reg <= OCNT_W'(ODEPTH - 2));

    always_comb
    begin
        wptr_next = OPTR_W'(wptr_reg + OPTR_W'(wr.cnt));
        rptr_next = do_pop ? OPTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + OCNT_W'(wr.cnt) - OCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
        begin
            o_mem[wptr_reg] <= wr.r0;
        end
        if (wr.cnt == 2'd2)
        begin
            o_mem[OPTR_W'(wptr_reg + 1'b1)] <= wr.r1;
        end
    end

endmodule

// ----- rtl/core/json_byte_tokenizer_unit.sv -----
// Top level of the streaming JSON tokenizer.
// Each character waits in the input queue, and its results wait in the output buffer.
// Throughput: one character per cycle while the output buffer has room; the results of a character
// leave one at a time through the single-result output port after the four-entry buffer.
// Reset (rst_n low, asynchronous) empties both queues and returns the parser to idle.
module json_byte_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic [2:0]  error_code,
    output logic [1:0]  token_kind,
    output logic [15:0] number_value,
    output logic        bool_value,
    output logic [7:0]  text_char,
    output logic [3:0]  text_index,
    output logic [3:0]  nest_level,
    output logic        last
);
    import jbt_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    item_t push_item;
    item_t head_item;
    logic  space_ok;
    wr_t   wr;
    res_t  res;

    jbt_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    jbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head_item)
    );

    jbt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (head_item),
        .q_empty  (q_empty),
        .space_ok (space_ok),
        .q_pop    (q_pop),
        .wr       (wr)
    );

    jbt_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (res)
    );

    assign event_res    = res.ev;
    assign error_code   = res.err;
    assign token_kind   = res.kind;
    assign number_value = res.num;
    assign bool_value   = res.bval;
    assign text_char    = res.ch;
    assign text_index   = res.idx;
    assign nest_level   = res.nest;
    assign last         = res.last;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the streaming JSON tokenizer with a built-in token predictor
module testbench;
    import jbt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_char;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  event_res;
    logic [2:0]  error_code;
    logic [1:0]  token_kind;
    logic [15:0] number_value;
    logic        bool_value;
    logic [7:0]  text_char;
    logic [3:0]  text_index;
    logic [3:0]  nest_level;
    logic        last;

    // Predicted tokenizer state
    parse_state_t tok_state;
    sub_state_t   tok_sub;
    logic [3:0]   tok_depth;
    logic [15:0]  num_acc;
    logic         bool_seen;
    logic [3:0]   text_len;

    res_t expected_events [$];
    res_t step_events [2];
    int   step_count;
    res_t oldest_event;
    int   fail_count = 0;
    int   stall_cycles = 0;
    logic quiet = 1'b0;
    logic dive_mode = 1'b0;

    json_byte_tokenizer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .error_code   (error_code),
        .token_kind   (token_kind),
        .number_value (number_value),
        .bool_value   (bool_value),
        .text_char    (text_char),
        .text_index   (text_index),
        .nest_level   (nest_level),
        .last         (last)
    );

    always #2 clk = ~clk;

    function automatic void clear_tokenizer();
        tok_state = ST_IDLE;
        tok_sub   = SUB_NONE;
        tok_depth = 4'd0;
        num_acc   = 16'd0;
        bool_seen = 1'b0;
        text_len  = 4'd0;
    endfunction

    // Error code and the other fields read zero unless the event sets them; nest takes the current depth
    function automatic void note_event(input evt_t ev, input err_t err = ERR_BRACE,
                                       input kind_t kind = KIND_STR,
                                       input logic [15:0] num = 16'd0,
                                       input logic bval = 1'b0,
                                       input logic [7:0] ch = 8'd0,
                                       input logic [3:0] idx = 4'd0);
        step_events[step_count].ev   = ev;
        step_events[step_count].err  = err;
        step_events[step_count].kind = kind;
        step_events[step_count].num  = num;
        step_events[step_count].bval = bval;
        step_events[step_count].ch   = ch;
        step_events[step_count].idx  = idx;
        step_events[step_count].nest = tok_depth;
        step_events[step_count].last = 1'b0;
        step_count++;
    endfunction

    function automatic void tokenize_char(input logic [7:0] c);
        logic        structural;
        logic        finished;
        kind_t       kind;
        logic        bval;
        logic [3:0]  len;
        logic [15:0] num;
        logic        is_digit;
        logic        is_alpha;
        int          i;
        structural = 1'b1;
        finished   = 1'b0;
        kind       = KIND_STR;
        bval       = 1'b0;
        len        = 4'd0;
        num        = 16'd0;
        step_count = 0;
        is_digit   = (c >= CH_ZERO && c <= CH_NINE);
        is_alpha   = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        if (tok_sub != SUB_STR
            && (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR))
            return;
        if (c == CH_NUL || c == CH_ESC) begin
            clear_tokenizer();
            note_event(EV_RESET);
        end else begin
            case (tok_sub)
                SUB_NUM:
                    if (is_digit)
                        num_acc = num_acc * 16'd10 + 16'(c - CH_ZERO);
                    else begin
                        finished = 1'b1;
                        kind     = KIND_NUM;
                        num      = num_acc;
                    end
                SUB_BOOL:
                    if (!is_alpha) begin
                        finished = 1'b1;
                        kind     = KIND_BOOL;
                        bval     = bool_seen;
                    end
                SUB_STR:
                    if (c == CH_QUOTE) begin
                        finished   = 1'b1;
                        len        = text_len;
                        structural = 1'b0;
                    end else if (text_len < TEXT_LAST) begin
                        note_event(EV_TEXT, ERR_BRACE, KIND_STR, 16'd0, 1'b0, c, text_len);
                        text_len = text_len + 4'd1;
                    end
                default: ;
            endcase

            if (finished) begin
                tok_sub = SUB_NONE;
                if (tok_state == ST_NAME) begin
                    tok_state = ST_SEP;
                    note_event(EV_NAME_DONE, ERR_BRACE, kind, num, bval, 8'd0, len);
                end else if (tok_state == ST_ARRAY) begin
                    tok_state = ST_ACONT;
                    note_event(EV_ELEM_DONE, ERR_BRACE, kind, num, bval, 8'd0, len);
                end else begin
                    tok_state = ST_CONT;
                    note_event(EV_VALUE_DONE, ERR_BRACE, kind, num, bval, 8'd0, len);
                end
            end

            // A delimiter that closed a number or bool is parsed again here
            if (tok_sub == SUB_NONE && structural) begin
                case (tok_state)
                    ST_IDLE:
                        if (c == CH_LBRACE) begin
                            tok_state = ST_NAME;
                            note_event(EV_OPEN);
                        end else
                            note_event(EV_ERROR, ERR_BRACE);
                    ST_NAME:
                        if (c == CH_RBRACE) begin
                            tok_state = ST_IDLE;
                            note_event(EV_EMPTY_CLOSE);
                        end else if (c == CH_QUOTE) begin
                            tok_sub  = SUB_STR;
                            text_len = 4'd0;
                        end else
                            note_event(EV_ERROR, ERR_QUOTE);
                    ST_SEP:
                        if (c == CH_COLON)
                            tok_state = ST_VALUE;
                        else
                            note_event(EV_ERROR, ERR_COLON);
                    ST_VALUE, ST_ARRAY:
                        if (c == CH_QUOTE) begin
                            tok_sub  = SUB_STR;
                            text_len = 4'd0;
                        end else if (is_digit) begin
                            tok_sub = SUB_NUM;
                            num_acc = 16'(c - CH_ZERO);
                        end else if (c == CH_LO_T || c == CH_UP_T
                                     || c == CH_LO_F || c == CH_UP_F) begin
                            tok_sub   = SUB_BOOL;
                            bool_seen = (c == CH_LO_T || c == CH_UP_T);
                        end else if (c == CH_LBRACK && tok_state == ST_VALUE) begin
                            tok_state = ST_ARRAY;
                            note_event(EV_ARRAY_OPEN);
                        end else if (c == CH_LBRACE) begin
                            if (tok_depth >= DEPTH_MAX)
                                note_event(EV_ERROR, ERR_DEPTH);
                            else begin
                                tok_depth = tok_depth + 4'd1;
                                tok_state = ST_NAME;
                                note_event(EV_OPEN);
                            end
                        end else
                            note_event(EV_ERROR, ERR_VALUE);
                    ST_CONT:
                        if (c == CH_RBRACE) begin
                            if (tok_depth != 4'd0) begin
                                tok_depth = tok_depth - 4'd1;
                                note_event(EV_CLOSE);
                            end else begin
                                tok_state = ST_IDLE;
                                note_event(EV_ROOT_CLOSE);
                            end
                        end else if (c == CH_COMMA)
                            tok_state = ST_NAME;
                        else
                            note_event(EV_ERROR, ERR_CONT);
                    ST_ACONT:
                        if (c == CH_RBRACK) begin
                            tok_state = ST_CONT;
                            note_event(EV_ARRAY_CLOSE);
                        end else if (c == CH_COMMA)
                            tok_state = ST_ARRAY;
                        else
                            note_event(EV_ERROR, ERR_ACONT);
                    default: ;
                endcase
            end
        end

        if (step_count > 0)
            step_events[step_count - 1].last = 1'b1;
        for (i = 0; i < step_count; i++)
            expected_events.push_back(step_events[i]);
    endfunction

    // Delimiter that ends a number or bool and fits the container it sits in
    function automatic logic [7:0] close_char();
        if (tok_state == ST_ARRAY)
            return ($urandom_range(0, 2) == 0) ? CH_RBRACK : CH_COMMA;
        return (dive_mode || $urandom_range(0, 1)) ? CH_COMMA : CH_RBRACE;
    endfunction

    // Mostly well-formed next byte for the current parse position, with some noise
    function automatic logic [7:0] next_json_char(input int noise_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick == 0)
            return $urandom_range(0, 1) ? CH_NUL : CH_ESC;
        if (pick <= noise_pct)
            return 8'($urandom_range(0, 255));
        if (tok_sub != SUB_STR && pick >= 90) begin
            case ($urandom_range(0, 3))
                0:       return CH_SPACE;
                1:       return CH_TAB;
                2:       return CH_NL;
                default: return CH_CR;
            endcase
        end
        case (tok_sub)
            SUB_STR: begin
                if ($urandom_range(0, 9) == 0)
                    return CH_QUOTE;
                pick = $urandom_range(CH_SPACE, 255);
                return (pick == CH_QUOTE) ? CH_LO_A : 8'(pick);
            end
            SUB_NUM:
                return ($urandom_range(0, 3) != 0) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                   : close_char();
            SUB_BOOL:
                return $urandom_range(0, 1)
                    ? 8'($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25))
                    : close_char();
            default: ;
        endcase
        case (tok_state)
            ST_IDLE: begin
                dive_mode = dive_mode || ($urandom_range(0, 5) == 0);
                return CH_LBRACE;
            end
            ST_NAME:
                return (!dive_mode && $urandom_range(0, 7) == 0) ? CH_RBRACE : CH_QUOTE;
            ST_SEP:
                return CH_COLON;
            ST_VALUE, ST_ARRAY: begin
                if (tok_state == ST_VALUE && dive_mode) begin
                    // one open past the limit, then drop back to normal shapes
                    if (tok_depth == DEPTH_MAX)
                        dive_mode = 1'b0;
                    return CH_LBRACE;
                end
                case ($urandom_range(0, 9))
                    0, 1:    return CH_QUOTE;
                    2, 3, 4: return CH_ZERO + 8'($urandom_range(0, 9));
                    5, 6: begin
                        case ($urandom_range(0, 3))
                            0:       return CH_LO_T;
                            1:       return CH_UP_T;
                            2:       return CH_LO_F;
                            default: return CH_UP_F;
                        endcase
                    end
                    7:
                        return (tok_state == ST_VALUE || $urandom_range(0, 3) == 0)
                            ? CH_LBRACK : CH_QUOTE;
                    default: return CH_LBRACE;
                endcase
            end
            ST_CONT:
                return (dive_mode || $urandom_range(0, 1)) ? CH_COMMA : CH_RBRACE;
            ST_ACONT:
                return ($urandom_range(0, 2) == 0) ? CH_RBRACK : CH_COMMA;
            default:
                return CH_LBRACE;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Returns at the edge where the byte transfers
    task automatic send_char(input logic [7:0] c);
        tokenize_char(c);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_control_bytes();
        send_char(CH_ESC);
        send_char(CH_NUL);
        send_char(8'hff);
        send_text("{}");
    endtask

    task automatic test_array_values();
        // 65539 wraps to 3
        send_text("{\"a\":[65539,t]}");
    endtask

    task automatic test_token_delimiters();
        send_text("{\"\":F [}");
    endtask

    task automatic test_reset_in_string();
        send_text("{\"x");
        send_char(CH_ESC);
    endtask

    task automatic test_deep_nesting();
        dive_mode = 1'b1;
        repeat (150) send_char(next_json_char(0));
    endtask

    task automatic test_random_documents();
        repeat (250) send_char(next_json_char(5));
    endtask

    task automatic test_quiet_burst();
        quiet = 1'b1;
        repeat (120) send_char(next_json_char(5));
        quiet = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_char(next_json_char(5));
        wait_for_drain();
        repeat (30) send_char(next_json_char(5));
    endtask

    task automatic test_noise();
        repeat (80) send_char(next_json_char(40));
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_char   <= 8'd0;
        out_ready <= 1'b0;
        clear_tokenizer();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control_bytes();
        test_array_values();
        test_token_delimiters();
        test_reset_in_string();
        test_deep_nesting();
        test_random_documents();
        test_quiet_burst();
        test_drain_pause();
        test_noise();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("json_byte_tokenizer_unit verification clean");
        else
            $display("json_byte_tokenizer_unit verification failed");
        $finish;
    end

    // Result checker; the receiver stalls at random outside quiet stretches
    always @(posedge clk) begin
        if (rst_n) begin
            out_ready <= quiet || ($urandom_range(0, 99) >= 16);
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result transfer: event_res %0d", event_res);
                    fail_count++;
                end else begin
                    oldest_event = expected_events.pop_front();
                    check_field("event_res", oldest_event.ev, event_res);
                    check_field("error_code", oldest_event.err, error_code);
                    check_field("token_kind", oldest_event.kind, token_kind);
                    check_field("number_value", oldest_event.num, number_value);
                    check_field("bool_value", oldest_event.bval, bool_value);
                    check_field("text_char", oldest_event.ch, text_char);
                    check_field("text_index", oldest_event.idx, text_index);
                    check_field("nest_level", oldest_event.nest, nest_level);
                    check_field("last", oldest_event.last, last);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("json_byte_tokenizer_unit verification failed");
            $finish;
        end
    end

endmodule
